/* hw/rtl/tsw_pkg.sv */
// ----------------------------------------------------------------------------
// tsw_pkg
// shared types, character codes and color helpers of the text screen writer
// ----------------------------------------------------------------------------
package tsw_pkg;

    localparam logic OP_PUT  = 1'b0;
    localparam logic OP_READ = 1'b1;

    localparam logic [8:0] CODE_NEWLINE   = 9'd10;
    localparam logic [8:0] CODE_ESCAPE    = 9'd27;
    localparam logic [8:0] CODE_DIGIT_0   = 9'd48;
    localparam logic [8:0] CODE_DIGIT_9   = 9'd57;
    localparam logic [8:0] CODE_SGR_END   = 9'd109;
    localparam logic [8:0] CODE_BACKSPACE = 9'd256;

    localparam logic [6:0] CODE_LIMIT = 7'd100;

    localparam logic [6:0] SGR_RESET      = 7'd0;
    localparam logic [6:0] SGR_FG_FIRST   = 7'd30;
    localparam logic [6:0] SGR_FG_LAST    = 7'd37;
    localparam logic [6:0] SGR_FG_DEFAULT = 7'd39;
    localparam logic [6:0] SGR_BG_FIRST   = 7'd40;
    localparam logic [6:0] SGR_BG_LAST    = 7'd46;
    localparam logic [6:0] SGR_BG_WHITE   = 7'd47;
    localparam logic [6:0] SGR_BG_DEFAULT = 7'd49;

    localparam logic [2:0] COLOR_DEFAULT_FG = 3'd7;
    localparam logic [2:0] COLOR_DEFAULT_BG = 3'd0;

    localparam logic [15:0] BLANK_CELL = 16'h0720;

    typedef struct packed {
        logic       in_escape;
        logic [6:0] code_acc;
        logic [2:0] fg;
        logic [2:0] bg;
    } t_esc_state;

    typedef struct packed {
        logic is_newline;
        logic is_backspace;
        logic is_print;
    } t_char_class;

    // sgr color order to cga color index
    function automatic logic [2:0] cga_index(input logic [2:0] sgr);
        logic [2:0] idx;
        case (sgr)
            3'd0:    idx = 3'd0;
            3'd1:    idx = 3'd4;
            3'd2:    idx = 3'd2;
            3'd3:    idx = 3'd6;
            3'd4:    idx = 3'd1;
            3'd5:    idx = 3'd5;
            3'd6:    idx = 3'd3;
            default: idx = 3'd7;
        endcase
        return idx;
    endfunction

    function automatic logic [15:0] attr_word(input t_esc_state s);
        return {1'b0, s.bg, 1'b0, s.fg, 8'h00};
    endfunction

endpackage

/* hw/rtl/text_screen_writer_with_sgr_colors_top.sv */
// ----------------------------------------------------------------------------
// text_screen_writer_with_sgr_colors_top
// text screen writer: cell store, cursor, sgr color escapes and scrolling
// ----------------------------------------------------------------------------
// Input channel (i_in_valid / o_in_ready) carries one item: op 0 puts a
// character at the cursor, op 1 reads the cell at i_read_address. Output
// channel (o_out_valid / i_out_ready) returns one item per input item: the
// cell contents or the attribute word in use, and the cursor index.
// The cells live in one synchronous memory of COLUMNS*TEXT_ROWS words with
// one write and one read port; addresses past the screen read as zero.
// Steps of an item, up to the output register:
//   printable character: cell write, then blank at the new cursor
//   newline, backspace, escape bytes: no step beyond acceptance
//   read: registered memory read
//   scroll: one cell moved per cycle through the single read and write
//   port, then a drain step for the last move
// One item is in work at a time; a new item is taken as soon as the previous
// one has reached the output register, even if that result is not yet taken.
// If the receiver stalls with a result pending, the finished result waits
// inside until the output register frees up.
// After reset the store is cleared one cell per cycle, before the first
// item is accepted.
// ----------------------------------------------------------------------------
module text_screen_writer_with_sgr_colors_top
    import tsw_pkg::*;
#(
    parameter int COLUMNS   = 80,
    parameter int TEXT_ROWS = 24
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_op,
    input  logic [8:0]  i_char_code,
    input  logic [10:0] i_read_address,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [15:0] o_cell_value,
    output logic [10:0] o_cursor_position
);

    localparam int VISIBLE = COLUMNS * TEXT_ROWS;
    localparam int CW      = $clog2(VISIBLE);
    localparam int PW      = CW + 1;
    localparam int LW      = $clog2(COLUMNS);
    localparam int EW      = (PW > 11) ? PW : 11;

    localparam logic [PW-1:0] POS_END        = PW'(VISIBLE);
    localparam logic [PW-1:0] POS_COLUMNS    = PW'(COLUMNS);
    localparam logic [CW-1:0] LAST_CELL      = CW'(VISIBLE - 1);
    localparam logic [CW-1:0] LAST_ROW_START = CW'(VISIBLE - COLUMNS);
    localparam logic [CW-1:0] ROW_STEP       = CW'(COLUMNS);
    localparam logic [LW-1:0] LAST_COL       = LW'(COLUMNS - 1);
    localparam logic [EW-1:0] ADDR_END       = EW'(VISIBLE);

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_READ   = 3'd2;
    localparam logic [2:0] S_BLANK  = 3'd3;
    localparam logic [2:0] S_SCROLL = 3'd4;
    localparam logic [2:0] S_DRAIN  = 3'd5;
    localparam logic [2:0] S_RESULT = 3'd6;

    localparam logic [1:0] KIND_MEM   = 2'd0;
    localparam logic [1:0] KIND_ZERO  = 2'd1;
    localparam logic [1:0] KIND_BLANK = 2'd2;

    logic [2:0]    r_state;
    logic [2:0]    n_state;
    logic [CW-1:0] r_sweep;
    logic [CW-1:0] r_cursor;
    logic [LW-1:0] r_col;
    t_esc_state    r_esc;
    logic [15:0]   r_res_value;
    logic          r_rd_in_range;
    logic          r_wr_pend;
    logic [CW-1:0] r_wr_addr;
    logic [1:0]    r_wr_kind;
    logic [15:0]   r_rd_data;
    logic          r_out_valid;
    logic [15:0]   r_out_value;
    logic [10:0]   r_out_cursor;
    logic [15:0]   r_cells [VISIBLE];

    logic          w_in_acc;
    logic          w_out_free;
    t_esc_state    w_esc_next;
    t_char_class   w_class;
    logic [PW-1:0] w_pos;
    logic [LW-1:0] w_col_next;
    logic          w_scroll;
    logic [CW-1:0] w_cursor_next;
    logic [EW-1:0] w_addr_ext;
    logic          w_rd_in_range;
    logic [CW-1:0] w_rd_addr;
    logic          w_sweep_src_mem;
    logic [15:0]   w_read_value;
    logic          w_we;
    logic [CW-1:0] w_wr_addr;
    logic [15:0]   w_wr_data;
    logic          w_load;
    logic [15:0]   w_load_value;
    logic [CW-1:0] w_load_cursor;
    logic [EW-1:0] w_load_cursor_ext;

    tsw_esc_parser u_esc_parser (
        .i_char_code (i_char_code),
        .i_state     (r_esc),
        .o_state     (w_esc_next),
        .o_class     (w_class)
    );

    assign o_in_ready  = (r_state == S_IDLE);
    assign w_in_acc    = i_in_valid && o_in_ready;
    assign w_out_free  = !r_out_valid || i_out_ready;

    assign w_addr_ext      = EW'(i_read_address);
    assign w_rd_in_range   = w_addr_ext < ADDR_END;
    assign w_sweep_src_mem = r_sweep < LAST_ROW_START;
    assign w_read_value    = r_rd_in_range ? r_rd_data : 16'h0000;
    // during a scroll the source cell sits one row below the destination
    assign w_rd_addr = (r_state == S_SCROLL) ? r_sweep + ROW_STEP : w_addr_ext[CW-1:0];

    // cursor movement for a put item
    always_comb begin
        w_pos      = {1'b0, r_cursor};
        w_col_next = r_col;
        if (w_class.is_newline) begin
            w_pos      = {1'b0, r_cursor} - PW'(r_col) + POS_COLUMNS;
            w_col_next = '0;
        end else if (w_class.is_backspace) begin
            if (r_cursor != '0) begin
                w_pos      = {1'b0, r_cursor} - PW'(1);
                w_col_next = (r_col == '0) ? LAST_COL : r_col - LW'(1);
            end
        end else if (w_class.is_print) begin
            w_pos      = {1'b0, r_cursor} + PW'(1);
            w_col_next = (r_col == LAST_COL) ? '0 : r_col + LW'(1);
        end
    end

    // the cursor can only run past the screen by landing on its end
    assign w_scroll      = (w_pos == POS_END);
    assign w_cursor_next = w_scroll ? LAST_ROW_START : w_pos[CW-1:0];

    // write port select
    always_comb begin
        w_we      = 1'b0;
        w_wr_addr = r_cursor;
        w_wr_data = BLANK_CELL;
        case (r_state)
            S_CLEAR: begin
                w_we      = 1'b1;
                w_wr_addr = r_sweep;
                w_wr_data = 16'h0000;
            end
            S_IDLE: begin
                if (w_in_acc && i_op == OP_PUT) begin
                    if (w_class.is_print) begin
                        w_we      = 1'b1;
                        w_wr_addr = r_cursor;
                        w_wr_data = {8'h00, i_char_code[7:0]} | attr_word(r_esc);
                    end else if (!w_scroll) begin
                        w_we      = 1'b1;
                        w_wr_addr = w_cursor_next;
                    end
                end
            end
            S_BLANK: begin
                w_we = 1'b1;
            end
            S_SCROLL, S_DRAIN: begin
                w_we      = r_wr_pend;
                w_wr_addr = r_wr_addr;
                case (r_wr_kind)
                    KIND_MEM:   w_wr_data = r_rd_data;
                    KIND_BLANK: w_wr_data = BLANK_CELL;
                    default:    w_wr_data = 16'h0000;
                endcase
            end
            default: begin
                w_we = 1'b0;
            end
        endcase
    end

    // sequencing and result hand-off
    always_comb begin
        n_state       = r_state;
        w_load        = 1'b0;
        w_load_value  = r_res_value;
        w_load_cursor = r_cursor;
        case (r_state)
            S_CLEAR: begin
                if (r_sweep == LAST_CELL) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_in_acc) begin
                    if (i_op == OP_READ) begin
                        n_state = S_READ;
                    end else if (w_scroll) begin
                        n_state = S_SCROLL;
                    end else if (w_class.is_print) begin
                        n_state = S_BLANK;
                    end else if (w_out_free) begin
                        w_load        = 1'b1;
                        w_load_value  = attr_word(w_esc_next);
                        w_load_cursor = w_cursor_next;
                    end else begin
                        n_state = S_RESULT;
                    end
                end
            end
            S_READ: begin
                w_load_value = w_read_value;
                if (w_out_free) begin
                    w_load  = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_state = S_RESULT;
                end
            end
            S_BLANK, S_DRAIN: begin
                if (w_out_free) begin
                    w_load  = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_state = S_RESULT;
                end
            end
            S_SCROLL: begin
                if (r_sweep == LAST_CELL) begin
                    n_state = S_DRAIN;
                end
            end
            S_RESULT: begin
                if (w_out_free) begin
                    w_load  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign w_load_cursor_ext = EW'(w_load_cursor);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_CLEAR;
            r_sweep       <= '0;
            r_cursor      <= '0;
            r_col         <= '0;
            r_esc.in_escape <= 1'b0;
            r_esc.code_acc  <= '0;
            r_esc.fg        <= COLOR_DEFAULT_FG;
            r_esc.bg        <= COLOR_DEFAULT_BG;
            r_wr_pend     <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR || r_state == S_SCROLL) begin
                r_sweep <= (r_sweep == LAST_CELL) ? '0 : r_sweep + CW'(1);
            end
            case (r_state)
                S_IDLE: begin
                    r_wr_pend <= 1'b0;
                    if (w_in_acc) begin
                        r_rd_in_range <= w_rd_in_range;
                        if (i_op == OP_PUT) begin
                            r_esc       <= w_esc_next;
                            r_cursor    <= w_cursor_next;
                            r_col       <= w_scroll ? '0 : w_col_next;
                            r_res_value <= attr_word(w_esc_next);
                        end
                    end
                end
                S_READ: begin
                    r_res_value <= w_read_value;
                end
                S_SCROLL: begin
                    r_wr_pend <= 1'b1;
                    r_wr_addr <= r_sweep;
                    if (w_sweep_src_mem) begin
                        r_wr_kind <= KIND_MEM;
                    end else if (r_sweep == LAST_ROW_START) begin
                        r_wr_kind <= KIND_BLANK;
                    end else begin
                        r_wr_kind <= KIND_ZERO;
                    end
                end
                S_DRAIN: begin
                    r_wr_pend <= 1'b0;
                end
                default: begin
                    r_wr_pend <= r_wr_pend;
                end
            endcase
            if (w_load) begin
                r_out_valid  <= 1'b1;
                r_out_value  <= w_load_value;
                r_out_cursor <= w_load_cursor_ext[10:0];
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // cell store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_cells[w_wr_addr] <= w_wr_data;
        end
        r_rd_data <= r_cells[w_rd_addr];
    end

    assign o_out_valid       = r_out_valid;
    assign o_cell_value      = r_out_value;
    assign o_cursor_position = r_out_cursor;

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |-> w_out_free)
        else $error("result loaded over a pending result");

    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, r_cursor} < POS_END) && (r_col <= LAST_COL))
        else $error("cursor outside the screen");

    a_scroll_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCROLL && r_sweep == '0) |-> !r_wr_pend)
        else $error("stale cell move at scroll start");

    a_print_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && i_op == OP_PUT && w_class.is_print)
            |=> (r_state == S_BLANK || r_state == S_SCROLL))
        else $error("printed item skipped the blank write");

endmodule

/* hw/rtl/tsw_esc_parser.sv */
// ----------------------------------------------------------------------------
// tsw_esc_parser
// classifies a character and works out the next escape parser and color state
// ----------------------------------------------------------------------------
module tsw_esc_parser
    import tsw_pkg::*;
(
    input  logic [8:0]  i_char_code,
    input  t_esc_state  i_state,
    output t_esc_state  o_state,
    output t_char_class o_class
);

    logic        w_is_digit;
    logic [3:0]  w_digit;
    logic [10:0] w_acc_wide;
    logic [10:0] w_acc_sum;
    logic [6:0]  w_code;
    logic [6:0]  w_fg_off;
    logic [6:0]  w_bg_off;

    assign w_is_digit = (i_char_code >= CODE_DIGIT_0) && (i_char_code <= CODE_DIGIT_9);
    assign w_digit    = 4'(i_char_code - CODE_DIGIT_0);
    assign w_acc_wide = 11'(i_state.code_acc);
    // acc * 10 + digit
    assign w_acc_sum  = (w_acc_wide << 3) + (w_acc_wide << 1) + 11'(w_digit);
    assign w_code     = i_state.code_acc;
    assign w_fg_off   = w_code - SGR_FG_FIRST;
    assign w_bg_off   = w_code - SGR_BG_FIRST;

    always_comb begin
        o_state = i_state;
        o_class = '0;
        if (i_char_code == CODE_NEWLINE) begin
            o_class.is_newline = 1'b1;
        end else if (i_char_code == CODE_BACKSPACE) begin
            o_class.is_backspace = 1'b1;
        end else if (i_state.in_escape) begin
            if (w_is_digit) begin
                o_state.code_acc = (w_acc_sum > 11'(CODE_LIMIT)) ? CODE_LIMIT
                                                                 : w_acc_sum[6:0];
            end else begin
                if (i_char_code == CODE_SGR_END) begin
                    o_state.in_escape = 1'b0;
                end
                if (w_code == SGR_RESET) begin
                    o_state.fg = COLOR_DEFAULT_FG;
                    o_state.bg = COLOR_DEFAULT_BG;
                end else if (w_code >= SGR_FG_FIRST && w_code <= SGR_FG_LAST) begin
                    o_state.fg = cga_index(w_fg_off[2:0]);
                end else if (w_code == SGR_FG_DEFAULT) begin
                    o_state.fg = COLOR_DEFAULT_FG;
                end else if (w_code >= SGR_BG_FIRST && w_code <= SGR_BG_LAST) begin
                    o_state.bg = cga_index(w_bg_off[2:0]);
                end else if (w_code == SGR_BG_WHITE || w_code == SGR_BG_DEFAULT) begin
                    o_state.bg = COLOR_DEFAULT_BG;
                end
                o_state.code_acc = '0;
            end
        end else if (i_char_code == CODE_ESCAPE) begin
            o_state.in_escape = 1'b1;
        end else begin
            o_class.is_print = 1'b1;
        end
    end

endmodule

/* dv/tb_text_screen_writer_with_sgr_colors_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_text_screen_writer_with_sgr_colors_top
// checks the text screen writer against a cycle-free prediction of its screen
// ----------------------------------------------------------------------------
// Items go in over a valid/ready channel: printable bytes, newlines,
// backspaces, color escape sequences and cell reads. A scoreboard keeps its
// own copy of the screen, cursor and colors, predicts the result of every
// accepted item and compares each returned item field by field. A directed
// opening is followed by random sequences under four pacing phases.
// ----------------------------------------------------------------------------
module tb_text_screen_writer_with_sgr_colors_top;
    import tsw_pkg::*;

    localparam int SCREEN_COLS    = 80;
    localparam int SCREEN_ROWS    = 24;
    localparam int VISIBLE_SIZE   = SCREEN_COLS * SCREEN_ROWS;
    localparam int STORE_SIZE     = VISIBLE_SIZE + SCREEN_COLS;
    localparam int RANDOM_ITEMS   = 480;
    localparam int DRAIN_CYCLES   = 2000;
    localparam int WATCHDOG_LIMIT = 20000;

    localparam logic [8:0] CHAR_A         = 9'h041;
    localparam logic [8:0] CHAR_LBRACKET  = 9'h05B;
    localparam logic [8:0] CHAR_SEMICOLON = 9'h03B;
    localparam logic [8:0] CHAR_HOME      = 9'h048;
    localparam logic [8:0] CHAR_SPACE     = 9'h020;
    localparam logic [8:0] CHAR_TILDE     = 9'h07E;

    typedef enum int {
        PACE_FULL,
        PACE_SENDER_IDLE,
        PACE_RECEIVER_STALL,
        PACE_BOTH
    } pace_e;

    class screen_scoreboard;
        logic [15:0] cells [STORE_SIZE];
        logic [10:0] cursor_idx;
        logic        escape_mode;
        logic [6:0]  sgr_code;
        logic [2:0]  fg_color;
        logic [2:0]  bg_color;
        logic [2:0]  sgr_to_cga [8];
        logic [15:0] pending_cell_values [$];
        logic [10:0] pending_cursors [$];
        int          error_count;
        int          checked_count;
        int          scroll_count;
        int          read_count;

        function new();
            foreach (cells[i]) cells[i] = '0;
            cursor_idx    = '0;
            escape_mode   = 1'b0;
            sgr_code      = '0;
            fg_color      = COLOR_DEFAULT_FG;
            bg_color      = COLOR_DEFAULT_BG;
            sgr_to_cga    = '{3'd0, 3'd4, 3'd2, 3'd6, 3'd1, 3'd5, 3'd3, 3'd7};
            error_count   = 0;
            checked_count = 0;
            scroll_count  = 0;
            read_count    = 0;
        endfunction

        function logic [15:0] attribute();
            return {1'b0, bg_color, 1'b0, fg_color, 8'h00};
        endfunction

        function void apply_sgr(logic [6:0] code);
            if (code == SGR_RESET) begin
                fg_color = COLOR_DEFAULT_FG;
                bg_color = COLOR_DEFAULT_BG;
            end else if (code >= SGR_FG_FIRST && code <= SGR_FG_LAST) begin
                fg_color = sgr_to_cga[3'(code - SGR_FG_FIRST)];
            end else if (code == SGR_FG_DEFAULT) begin
                fg_color = COLOR_DEFAULT_FG;
            end else if (code >= SGR_BG_FIRST && code <= SGR_BG_LAST) begin
                bg_color = sgr_to_cga[3'(code - SGR_BG_FIRST)];
            end else if (code == SGR_BG_WHITE || code == SGR_BG_DEFAULT) begin
                bg_color = COLOR_DEFAULT_BG;
            end
        endfunction

        function void put_character(logic [8:0] code);
            int pos;
            int grown;
            pos = int'(cursor_idx);
            if (code == CODE_NEWLINE) begin
                pos += SCREEN_COLS - pos % SCREEN_COLS;
            end else if (code == CODE_BACKSPACE) begin
                if (pos > 0) pos--;
            end else if (escape_mode) begin
                if (code >= CODE_DIGIT_0 && code <= CODE_DIGIT_9) begin
                    grown = int'(sgr_code) * 10 + int'(code - CODE_DIGIT_0);
                    sgr_code = (grown > int'(CODE_LIMIT)) ? CODE_LIMIT : 7'(grown);
                end else begin
                    if (code == CODE_SGR_END) escape_mode = 1'b0;
                    apply_sgr(sgr_code);
                    sgr_code = '0;
                end
            end else if (code == CODE_ESCAPE) begin
                escape_mode = 1'b1;
            end else begin
                cells[pos] = attribute() | 16'(code[7:0]);
                pos++;
            end
            // cursor fell off the last row: move rows up, wipe the tail
            if (pos / SCREEN_COLS >= SCREEN_ROWS) begin
                for (int i = 0; i < (SCREEN_ROWS - 1) * SCREEN_COLS; i++)
                    cells[i] = cells[i + SCREEN_COLS];
                pos -= SCREEN_COLS;
                for (int i = pos; i < VISIBLE_SIZE; i++) cells[i] = '0;
                scroll_count++;
            end
            cells[pos] = BLANK_CELL;
            cursor_idx = 11'(pos);
        endfunction

        function void note_input(logic op, logic [8:0] code, logic [10:0] addr);
            if (op == OP_READ) begin
                pending_cell_values.push_back(
                    (int'(addr) < STORE_SIZE) ? cells[addr] : 16'h0000);
                read_count++;
            end else begin
                put_character(code);
                pending_cell_values.push_back(attribute());
            end
            pending_cursors.push_back(cursor_idx);
        endfunction

        function void check_result(logic [15:0] cell_value, logic [10:0] cursor_pos);
            logic [15:0] want_cell;
            logic [10:0] want_cursor;
            if (pending_cursors.size() == 0) begin
                $error("unexpected item: cell_value 16'h%04h, cursor_position %0d",
                       cell_value, cursor_pos);
                error_count++;
                return;
            end
            want_cell   = pending_cell_values.pop_front();
            want_cursor = pending_cursors.pop_front();
            checked_count++;
            if (cell_value !== want_cell) begin
                $error("cell_value: expected 16'h%04h, actual 16'h%04h",
                       want_cell, cell_value);
                error_count++;
            end
            if (cursor_pos !== want_cursor) begin
                $error("cursor_position: expected %0d, actual %0d",
                       want_cursor, cursor_pos);
                error_count++;
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic        op;
    logic [8:0]  char_code;
    logic [10:0] read_address;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [15:0] cell_value;
    logic [10:0] cursor_position;

    screen_scoreboard sb;
    pace_e            pace = PACE_FULL;
    int               items_sent = 0;
    int               quiet_cycles = 0;

    always #5 clk = ~clk;

    text_screen_writer_with_sgr_colors_top #(
        .COLUMNS   (SCREEN_COLS),
        .TEXT_ROWS (SCREEN_ROWS)
    ) dut (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_in_valid        (in_valid),
        .o_in_ready        (in_ready),
        .i_op              (op),
        .i_char_code       (char_code),
        .i_read_address    (read_address),
        .o_out_valid       (out_valid),
        .i_out_ready       (out_ready),
        .o_cell_value      (cell_value),
        .o_cursor_position (cursor_position)
    );

    always @(negedge clk) begin
        if (pace == PACE_RECEIVER_STALL) begin
            out_ready <= ($urandom_range(99) >= 79);
        end else if (pace == PACE_BOTH) begin
            out_ready <= ($urandom_range(99) >= 8);
        end else begin
            out_ready <= 1'b1;
        end
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if (in_valid && in_ready) sb.note_input(op, char_code, read_address);
            if (out_valid && out_ready) sb.check_result(cell_value, cursor_position);
        end
    end

    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles == WATCHDOG_LIMIT) begin
                $display("tb_text_screen_writer_with_sgr_colors_top: errors");
                $finish;
            end
        end
    end

    task automatic send_item(input logic item_op, input logic [8:0] code,
                             input logic [10:0] addr);
        @(negedge clk);
        while ((pace == PACE_SENDER_IDLE && $urandom_range(99) < 79) ||
               (pace == PACE_BOTH && $urandom_range(99) < 8)) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid     <= 1'b1;
        op           <= item_op;
        char_code    <= code;
        read_address <= addr;
        do @(posedge clk); while (!in_ready);
        items_sent++;
    endtask

    task automatic put_char(input logic [8:0] code);
        send_item(OP_PUT, code, 11'($urandom_range(STORE_SIZE - 1)));
    endtask

    task automatic read_cell(input int addr);
        send_item(OP_READ, 9'($urandom_range(256)), 11'(addr));
    endtask

    function automatic logic [8:0] random_glyph();
        logic [8:0] g;
        do begin
            if ($urandom_range(3) == 0) g = 9'($urandom_range(255));
            else g = 9'($urandom_range(int'(CHAR_SPACE), int'(CHAR_TILDE)));
        end while (g == CODE_NEWLINE || g == CODE_ESCAPE);
        return g;
    endfunction

    // decimal parameter of an sgr sequence; negative leaves it empty
    task automatic send_number(input int value);
        string digits;
        if (value >= 0) begin
            digits = $sformatf("%0d", value);
            for (int k = 0; k < digits.len(); k++) put_char(9'(digits[k]));
        end
    endtask

    task automatic send_color_escape();
        int params;
        int value;
        int roll;
        put_char(CODE_ESCAPE);
        put_char(CHAR_LBRACKET);
        params = $urandom_range(1, 3);
        for (int k = 0; k < params; k++) begin
            roll = $urandom_range(9);
            case (roll)
                0:       value = int'(SGR_RESET);
                1, 2, 3: value = 30 + $urandom_range(9);
                4, 5, 6: value = 40 + $urandom_range(9);
                7:       value = $urandom_range(127);
                8:       value = $urandom_range(100, 99999);
                default: value = -1;
            endcase
            send_number(value);
            if (k < params - 1) put_char(CHAR_SEMICOLON);
        end
        // mostly well formed, sometimes broken off
        roll = $urandom_range(19);
        if (roll < 17) put_char(CODE_SGR_END);
        else if (roll == 17) put_char(CHAR_HOME);
        else if (roll == 18) put_char(CODE_NEWLINE);
        else put_char(CODE_BACKSPACE);
    endtask

    task automatic send_random_sequence();
        int roll;
        int count;
        int addr;
        int row_base;
        roll = $urandom_range(99);
        if (roll < 30) begin
            repeat ($urandom_range(1, 12)) put_char(random_glyph());
        end else if (roll < 45) begin
            send_color_escape();
        end else if (roll < 60) begin
            repeat ($urandom_range(1, 4)) put_char(CODE_NEWLINE);
        end else if (roll < 68) begin
            repeat ($urandom_range(1, 3)) put_char(CODE_BACKSPACE);
        end else if (roll < 85) begin
            count = $urandom_range(1, 4);
            repeat (count) begin
                row_base = (int'(sb.cursor_idx) / SCREEN_COLS) * SCREEN_COLS;
                roll = $urandom_range(9);
                if (roll < 5) addr = row_base + $urandom_range(SCREEN_COLS - 1);
                else if (roll < 8) addr = $urandom_range(STORE_SIZE - 1);
                else addr = $urandom_range((SCREEN_ROWS - 2) * SCREEN_COLS,
                                           STORE_SIZE - 1);
                read_cell(addr);
            end
        end else if (roll < 90) begin
            // run past the end of the row to force a wrap
            count = SCREEN_COLS - int'(sb.cursor_idx) % SCREEN_COLS + $urandom_range(1, 3);
            repeat (count) put_char(random_glyph());
        end else begin
            repeat ($urandom_range(1, 3))
                send_item(1'($urandom_range(1)), 9'($urandom_range(256)),
                          11'($urandom_range(STORE_SIZE - 1)));
        end
    endtask

    initial begin
        int phase_end;
        sb           = new();
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        op           = OP_PUT;
        char_code    = '0;
        read_address = '0;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;

        // directed opening
        read_cell(0);
        read_cell(STORE_SIZE - 1);
        put_char(CHAR_A);
        put_char(9'h0FF);
        repeat (3) put_char(CODE_BACKSPACE);
        put_char(CODE_ESCAPE);
        put_char(CHAR_LBRACKET);
        put_char(CODE_DIGIT_0 + 9'd3);
        put_char(CODE_DIGIT_0 + 9'd1);
        put_char(CHAR_SEMICOLON);
        put_char(CODE_DIGIT_0 + 9'd4);
        put_char(CODE_DIGIT_0 + 9'd4);
        put_char(CODE_SGR_END);
        put_char(9'h000);
        put_char(CODE_ESCAPE);
        repeat (3) put_char(CODE_DIGIT_9);
        put_char(CODE_SGR_END);
        put_char(CODE_NEWLINE);
        read_cell(0);
        read_cell(1);

        for (int p = 0; p < 4; p++) begin
            pace      = pace_e'(p);
            phase_end = items_sent + RANDOM_ITEMS / 4;
            while (items_sent < phase_end) send_random_sequence();
        end

        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.pending_cursors.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("run covered %0d items (%0d cell reads) and %0d scrolls, %0d results checked",
                 items_sent, sb.read_count, sb.scroll_count, sb.checked_count);
        $display("pacing: full rate, sender idle, receiver stall, both idle");
        if (sb.error_count == 0) begin
            $display("tb_text_screen_writer_with_sgr_colors_top: clean");
        end else begin
            $display("tb_text_screen_writer_with_sgr_colors_top: errors");
        end
        $finish;
    end

endmodule
